[rtl/core/crro_pkg.sv]
// ----------------------------------------------------------------------------
// crro_pkg
// Shared types, constants and helper functions of the ring row offset core.
// ----------------------------------------------------------------------------
package crro_pkg;

  localparam int COORD_W        = 8;   // row offset, radius and root width
  localparam int OFF_W          = 9;   // signed output offset width
  localparam int NUM_SLOTS      = 8;   // symmetric positions per row
  localparam int SLOT_W         = 3;
  localparam int SQ_W           = 2 * COORD_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int MAX_RADIUS_DEF = 255;

  // One first-octant point (x, y) waiting to be folded out.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } row_entry_t;

  // Fill status of the queue between the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Positions in symmetric order; bit 2 swaps x and y, bit 1 negates x,
  // bit 0 negates y. A cleared bit marks a mirror duplicate.
  function automatic logic [NUM_SLOTS-1:0] slot_mask(input row_entry_t e);
    logic xnz;
    logic ynz;
    logic dif;
    logic [NUM_SLOTS-1:0] m;
    xnz  = (e.x != '0);
    ynz  = (e.y != '0);
    dif  = (e.x != e.y);
    m[0] = 1'b1;
    m[1] = ynz;
    m[2] = xnz;
    m[3] = xnz & ynz;
    m[4] = dif;
    m[5] = dif & xnz;
    m[6] = dif & ynz;
    m[7] = dif & xnz & ynz;
    return m;
  endfunction

  function automatic logic [SLOT_W-1:0] lowest_slot(input logic [NUM_SLOTS-1:0] m);
    logic [SLOT_W-1:0] sel;
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        sel = SLOT_W'(i);
      end
    end
    return sel;
  endfunction

  function automatic logic [OFF_W-1:0] encode_offset(input logic [COORD_W-1:0] mag,
                                                     input logic neg);
    logic [OFF_W-1:0] ext;
    ext = {1'b0, mag};
    return neg ? (~ext + OFF_W'(1)) : ext;
  endfunction

endpackage

[rtl/core/crro_front.sv]
// ----------------------------------------------------------------------------
// crro_front
// Holds the radius, accepts row offsets and finds the rounded square root of
// R*R - y*y two bits per cycle; rows inside the radius and octant are queued.
// ----------------------------------------------------------------------------
module crro_front #(
  parameter int MAX_RADIUS = crro_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          radius_we,
  input  logic [crro_pkg::COORD_W-1:0]  radius_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [crro_pkg::COORD_W-1:0]  row_offset,
  input  crro_pkg::q_stat_t             q_stat,
  output logic                          push,
  output crro_pkg::row_entry_t          push_entry
);
  import crro_pkg::*;

  localparam int REM_W  = COORD_W + 1;
  localparam int TRY_W  = COORD_W + 3;
  localparam int LAST_STEP = COORD_W - 1;

  logic [COORD_W-1:0] rad_c;
  logic [SQ_W-1:0]    rsq;
  logic [COORD_W-1:0] clamp;

  logic               busy;
  logic [SLOT_W-1:0]  step;
  logic               skip;
  logic [COORD_W-1:0] yreg;
  logic [SQ_W-1:0]    nsh;
  logic [REM_W-1:0]   rem;
  logic [COORD_W-1:0] root;

  logic [TRY_W-1:0]   t;
  logic [TRY_W-1:0]   trial;
  logic               ge;
  logic [REM_W-1:0]   rem_next;
  logic [COORD_W-1:0] root_next;
  logic [COORD_W-1:0] x_round;
  logic               last_step;
  logic               push_want;
  logic               hold;
  logic               accept;

  always_comb begin
    if (int'(radius_wdata) > MAX_RADIUS) begin
      clamp = COORD_W'(MAX_RADIUS);
    end else begin
      clamp = radius_wdata;
    end
  end

  // One digit of the restoring square root: bring down two bits of n.
  always_comb begin
    t         = {rem, nsh[SQ_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    ge        = (t >= trial);
    rem_next  = ge ? REM_W'(t - trial) : t[REM_W-1:0];
    root_next = {root[COORD_W-2:0], ge};
    // Round up when floor^2 + floor < n, that is when the remainder exceeds the root.
    x_round   = root_next + COORD_W'(rem_next > {1'b0, root_next});
  end

  assign last_step  = busy && (step == SLOT_W'(LAST_STEP));
  assign push_want  = last_step && !skip && (yreg <= x_round);
  assign hold       = push_want && q_stat.full;
  assign in_stall   = busy && !(last_step && !hold);
  assign accept     = in_valid && !in_stall;
  assign push       = push_want && !q_stat.full;
  assign push_entry = '{x: x_round, y: yreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      rad_c <= COORD_W'(1);
      rsq   <= SQ_W'(1);
      busy  <= 1'b0;
      step  <= '0;
    end else begin
      if (radius_we) begin
        rad_c <= clamp;
        rsq   <= SQ_W'(clamp) * SQ_W'(clamp);
      end
      if (accept) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy && !hold) begin
        step <= step + SLOT_W'(1);
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      yreg <= row_offset;
      skip <= (row_offset >= rad_c);
      nsh  <= rsq - SQ_W'(row_offset) * SQ_W'(row_offset);
      rem  <= '0;
      root <= '0;
    end else if (busy && !hold) begin
      nsh  <= {nsh[SQ_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

[rtl/core/crro_queue.sv]
// ----------------------------------------------------------------------------
// crro_queue
// Short first-in first-out queue of first-octant points between the front
// and the back.
// ----------------------------------------------------------------------------
module crro_queue #(
  parameter int DEPTH = crro_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  crro_pkg::row_entry_t  push_entry,
  input  logic                  pop,
  output crro_pkg::row_entry_t  head,
  output crro_pkg::q_stat_t     q_stat
);
  import crro_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  row_entry_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/core/crro_back.sv]
// ----------------------------------------------------------------------------
// crro_back
// Folds each queued point out into its symmetric ring offsets, one per cycle
// while the receiver does not stall, into a registered output stage.
// ----------------------------------------------------------------------------
module crro_back (
  input  logic                              clk,
  input  logic                              rst,
  input  crro_pkg::row_entry_t              head,
  input  crro_pkg::q_stat_t                 q_stat,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [crro_pkg::OFF_W-1:0] offset_x,
  output logic signed [crro_pkg::OFF_W-1:0] offset_y,
  output logic                              last_offset
);
  import crro_pkg::*;

  logic [NUM_SLOTS-1:0] cur_mask;
  row_entry_t           cur;

  logic                 advance;
  logic                 from_queue;
  logic                 have;
  row_entry_t           src;
  logic [NUM_SLOTS-1:0] src_mask;
  logic [SLOT_W-1:0]    sel;
  logic [NUM_SLOTS-1:0] rest;
  logic [COORD_W-1:0]   mag_x;
  logic [COORD_W-1:0]   mag_y;

  // A fresh row is taken straight from the queue head so rows run back to back.
  always_comb begin
    advance    = !out_valid || !out_stall;
    from_queue = (cur_mask == '0);
    have       = !from_queue || !q_stat.empty;
    src        = from_queue ? head : cur;
    src_mask   = from_queue ? slot_mask(head) : cur_mask;
    sel        = lowest_slot(src_mask);
    rest       = src_mask & ~(NUM_SLOTS'(1) << sel);
    mag_x      = sel[2] ? src.y : src.x;
    mag_y      = sel[2] ? src.x : src.y;
    pop        = advance && from_queue && !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_mask  <= '0;
    end else if (advance) begin
      out_valid <= have;
      if (have) begin
        cur_mask <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && have) begin
      cur         <= src;
      offset_x    <= encode_offset(mag_x, sel[1]);
      offset_y    <= encode_offset(mag_y, sel[0]);
      last_offset <= (rest == '0);
    end
  end

endmodule

[rtl/core/circle_ring_row_offsets_core.sv]
// ----------------------------------------------------------------------------
// circle_ring_row_offsets_core
// Expands first-octant rows of a digital circle into ring pixel offsets.
// ----------------------------------------------------------------------------
// Usage:
//   radius_we/radius_wdata write the ring radius (reset value 1), clamped to
//   MAX_RADIUS. Write it only while no row is in flight.
//   The input channel (in_valid, in_stall, row_offset) takes one row offset y
//   per transaction. The output channel (out_valid, out_stall, offset_x,
//   offset_y, last_offset) returns zero to eight offsets per row in
//   symmetric order; last_offset marks the final one of a row.
// Timing:
//   The front solves one row at a time in the two-bits-per-cycle square
//   root unit and accepts the next row only in its final root step. The back
//   emits one offset per cycle while the receiver does not stall. The first
//   offset of a row reaches the output register through the queue; rows
//   without offsets emit nothing. A two-entry queue separates the two halves,
//   so a stalled receiver only stops the front once the queue is full.
// Reset: synchronous and active high; clears the queue and the output stage
//   and restores the radius to 1.
// ----------------------------------------------------------------------------
module circle_ring_row_offsets_core #(
  parameter int MAX_RADIUS = crro_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              radius_we,
  input  logic [crro_pkg::COORD_W-1:0]      radius_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [crro_pkg::COORD_W-1:0]      row_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [crro_pkg::OFF_W-1:0] offset_x,
  output logic signed [crro_pkg::OFF_W-1:0] offset_y,
  output logic                              last_offset
);
  import crro_pkg::*;

  logic       push;
  row_entry_t push_entry;
  logic       pop;
  row_entry_t head;
  q_stat_t    q_stat;

  crro_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .radius_we   (radius_we),
    .radius_wdata(radius_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .row_offset  (row_offset),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry)
  );

  crro_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  crro_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .last_offset(last_offset)
  );

endmodule

[rtl/core/crro_checker.sv]
// ----------------------------------------------------------------------------
// crro_port_checker
// Port-level assertions for the ring row offset core.
// ----------------------------------------------------------------------------
module crro_port_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [crro_pkg::OFF_W-1:0] offset_x,
  input logic signed [crro_pkg::OFF_W-1:0] offset_y,
  input logic                              last_offset
);
  import crro_pkg::*;

  logic row_start;
  logic out_take;

  assign out_take = out_valid && !out_stall;

  // The next offset delivered opens a new row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_start <= 1'b1;
    end else if (out_take) begin
      row_start <= last_offset;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_row_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("row accepted while the previous one is still being solved");

  a_row_first: assert property (@(posedge clk) disable iff (rst)
    out_take && row_start |-> !offset_x[OFF_W-1] && !offset_y[OFF_W-1]
                              && (offset_x >= offset_y))
    else $error("row does not open with its first-octant point");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(offset_x) && $stable(offset_y)
                               && $stable(last_offset))
    else $error("stalled output transaction changed");

endmodule

bind circle_ring_row_offsets_core crro_port_checker u_crro_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .offset_x   (offset_x),
  .offset_y   (offset_y),
  .last_offset(last_offset)
);

[verif/crro_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crro_checker
// Watches both channels and the radius port of the ring row offset core.
// Every accepted row is folded into its expected ring offsets. Every accepted
// output transaction is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module crro_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              radius_we,
  input  logic [crro_pkg::COORD_W-1:0]      radius_wdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [crro_pkg::COORD_W-1:0]      row_offset,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [crro_pkg::OFF_W-1:0] offset_x,
  input  logic signed [crro_pkg::OFF_W-1:0] offset_y,
  input  logic                              last_offset,
  output int                                errors,
  output int                                pending
);
  import crro_pkg::*;

  typedef struct packed {
    logic signed [OFF_W-1:0] x;
    logic signed [OFF_W-1:0] y;
    logic                    last;
  } ring_offset_t;

  ring_offset_t          ring_offsets_q[$];
  logic [COORD_W-1:0]    radius_copy;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Largest root with root*root <= n, bumped by one where that rounds better.
  function automatic int unsigned rounded_root(input int unsigned n);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    if (root * root + root < n) begin
      root++;
    end
    return root;
  endfunction

  function automatic logic signed [OFF_W-1:0] signed_offset(input int unsigned mag,
                                                            input logic neg);
    logic [OFF_W-1:0] m;
    m = OFF_W'(mag);
    return neg ? (OFF_W'(0) - m) : m;
  endfunction

  // Folds one row into its ring offsets and queues them in output order.
  task automatic fold_row(input logic [COORD_W-1:0] y);
    int unsigned  r;
    int unsigned  yy;
    int unsigned  x;
    int unsigned  first;
    int unsigned  second;
    logic         swap;
    logic         neg_first;
    logic         neg_second;
    ring_offset_t row_offsets[$];
    ring_offset_t item;
    r  = (radius_copy > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_copy;
    yy = y;
    if (yy >= r) begin
      return;
    end
    x = rounded_root(r * r - yy * yy);
    if (yy > x) begin
      return;
    end
    // Slot bit 2 swaps the coordinates, bit 1 negates the first, bit 0 the
    // second. Negating a zero or swapping equal coordinates repeats a pixel.
    for (int s = 0; s < NUM_SLOTS; s++) begin
      swap       = s[2];
      neg_first  = s[1];
      neg_second = s[0];
      first      = swap ? yy : x;
      second     = swap ? x : yy;
      if (!((neg_first && first == 0) || (neg_second && second == 0) ||
            (swap && x == yy))) begin
        item.x    = signed_offset(first, neg_first);
        item.y    = signed_offset(second, neg_second);
        item.last = 1'b0;
        row_offsets = {row_offsets, item};
      end
    end
    row_offsets[row_offsets.size() - 1].last = 1'b1;
    foreach (row_offsets[i]) begin
      ring_offsets_q = {ring_offsets_q, row_offsets[i]};
    end
  endtask

  always @(posedge clk) begin
    ring_offset_t exp_offset;
    if (rst) begin
      radius_copy = 8'd1;
      ring_offsets_q.delete();
    end else begin
      if (radius_we) begin
        radius_copy = radius_wdata;
      end
      if (out_valid && !out_stall) begin
        if (ring_offsets_q.size() == 0) begin
          $error("unexpected offset x=%0d y=%0d last=%0b", offset_x, offset_y, last_offset);
          errors++;
        end else begin
          exp_offset = ring_offsets_q.pop_front();
          if (offset_x !== exp_offset.x) begin
            $error("offset_x: expected %0d, got %0d", exp_offset.x, offset_x);
            errors++;
          end
          if (offset_y !== exp_offset.y) begin
            $error("offset_y: expected %0d, got %0d", exp_offset.y, offset_y);
            errors++;
          end
          if (last_offset !== exp_offset.last) begin
            $error("last_offset: expected %0b, got %0b", exp_offset.last, last_offset);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        fold_row(row_offset);
      end
    end
    pending = ring_offsets_q.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives rows and radius settings into the ring row offset core.
// A directed pass covers the field extremes, rows on the octant diagonal,
// rows beyond the octant or the radius and a zero radius. Random phases then
// run under several radii with changing sender and receiver idle rates.
// ----------------------------------------------------------------------------
module testbench;
  import crro_pkg::*;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       radius_we    = 1'b0;
  logic [COORD_W-1:0]         radius_wdata = '0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [COORD_W-1:0]         row_offset   = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [OFF_W-1:0]    offset_x;
  logic signed [OFF_W-1:0]    offset_y;
  logic                       last_offset;
  int                         errors;
  int                         pending;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  circle_ring_row_offsets_core u_top (
    .clk          (clk),
    .rst          (rst),
    .radius_we    (radius_we),
    .radius_wdata (radius_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row_offset   (row_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .last_offset  (last_offset)
  );

  crro_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .radius_we    (radius_we),
    .radius_wdata (radius_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row_offset   (row_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .last_offset  (last_offset),
    .errors       (errors),
    .pending      (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offers one row and returns at the edge where the transaction completes.
  // The stall is sampled at the falling edge, where it has settled.
  task automatic send_row(input logic [COORD_W-1:0] y);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    row_offset <= y;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Holds off until every expected offset has come out, then lets rows that
  // produce no offsets clear the front.
  task automatic drain;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_radius(input logic [COORD_W-1:0] r);
    drain();
    radius_we    <= 1'b1;
    radius_wdata <= r;
    @(posedge clk);
    radius_we    <= 1'b0;
  endtask

  // Mostly rows inside the octant, some up to the radius, a few anywhere.
  function automatic logic [COORD_W-1:0] pick_row(input logic [COORD_W-1:0] r);
    int unsigned k;
    int unsigned octant_top;
    k          = $urandom_range(0, 99);
    octant_top = (int'(r) * 71) / 100;
    if (r == 0 || k < 10) begin
      return COORD_W'($urandom_range(0, 255));
    end else if (k < 30) begin
      return COORD_W'($urandom_range(0, int'(r) - 1));
    end
    return COORD_W'($urandom_range(0, octant_top));
  endfunction

  initial begin
    logic [COORD_W-1:0] r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset radius of one: only row zero gives offsets.
    send_row(8'd0);
    send_row(8'd1);
    send_row(8'd255);
    // Radius three puts row two on the diagonal.
    set_radius(8'd3);
    send_row(8'd0);
    send_row(8'd1);
    send_row(8'd2);
    send_row(8'd3);
    set_radius(8'd255);
    send_row(8'd0);
    send_row(8'd1);
    send_row(8'd128);
    send_row(8'd170);
    send_row(8'd180);
    send_row(8'd181);
    send_row(8'd182);
    send_row(8'd254);
    send_row(8'd255);
    // Radius five: row four lies beyond the octant.
    set_radius(8'd5);
    send_row(8'd3);
    send_row(8'd4);
    // A zero radius leaves every row out of range.
    set_radius(8'd0);
    send_row(8'd0);
    send_row(8'd7);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 16;
          recv_stall_pct = 74;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 16;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        if (sub == 0) begin
          r = COORD_W'($urandom_range(1, 255));
        end else if (sub == 1) begin
          r = COORD_W'($urandom_range(1, 20));
        end else begin
          r = (mode == 0) ? 8'd255 : COORD_W'($urandom_range(100, 255));
        end
        set_radius(r);
        repeat (29) begin
          if ($urandom_range(0, 39) == 0) begin
            drain();
          end
          send_row(pick_row(r));
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

[files.f]
rtl/core/crro_pkg.sv
rtl/core/crro_front.sv
rtl/core/crro_queue.sv
rtl/core/crro_back.sv
rtl/core/circle_ring_row_offsets_core.sv
rtl/core/crro_checker.sv
verif/crro_checker.sv
verif/testbench.sv
